>>> src/dmsr_pkg.sv
package dmsr_pkg;

    localparam int SPEED_W   = 16;
    localparam int STEP_W    = 15;
    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int FRAC_W    = 14;

    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    typedef logic signed [SPEED_W-1:0] t_speed;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_STEP  = 2'd0,
        CFG_PWM_PERIOD  = 2'd1,
        CFG_DUTY_OFFSET = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_SET  = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic {
        MOTOR_LEFT  = 1'b0,
        MOTOR_RIGHT = 1'b1
    } t_motor;

    typedef struct packed {
        logic [STEP_W-1:0]   accel_step;
        logic [PERIOD_W-1:0] pwm_period;
        logic [DUTY_W-1:0]   duty_offset;
    } t_cfg;

endpackage

>>> src/dual_motor_speed_ramp_pwm_core.sv
// channel   dir  handshake              payload
// s_axis    in   i_s_tvalid/o_s_tready   tdata target_speed, tuser cmd, motor
// m_axis    out  o_m_tvalid/i_m_tready   tdata four duty counts
// cfg       in   i_cfg_valid/o_cfg_ready index, data
//
// one item per cycle while the sink takes results; a tick item goes from the input
// register through ramp, multiply and clamp into the result register, where its
// result waits until the sink takes it
// set items update a target and give no result
// synchronous active-low reset clears configuration, targets, speeds and valid flags
// a stalled result holds in the output register while the input register still
// takes set items and one more tick item
module dual_motor_speed_ramp_pwm_core
    import dmsr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [15:0]            i_s_tdata,  // target_speed
    input  logic [1:0]             i_s_tuser,  // cmd, motor
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // left_forward, left_reverse, right_forward, right_reverse duty
    output logic [4*DUTY_W-1:0]    o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DAT_W-1:0]   i_cfg_data
);

    t_cfg   r_cfg;
    t_speed r_left_tgt, r_right_tgt, r_left_cur, r_right_cur;
    t_speed n_left_cur, n_right_cur;

    logic   r_in_vld;
    t_cmd   r_in_cmd;
    t_motor r_in_motor;
    t_speed r_in_speed;

    logic              r_out_vld;
    logic [DUTY_W-1:0] r_lf, r_lr, r_rf, r_rr;
    logic [DUTY_W-1:0] n_lf, n_lr, n_rf, n_rr;

    logic w_s_acc, w_out_free, w_adv, w_tick;

    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_adv      = r_in_vld && (r_in_cmd == CMD_SET || w_out_free);
    assign w_tick     = w_adv && r_in_cmd == CMD_TICK;
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    dmsr_ramp u_ramp_l (.i_cur(r_left_cur),  .i_tgt(r_left_tgt),  .i_cfg(r_cfg),
                        .o_next(n_left_cur));
    dmsr_ramp u_ramp_r (.i_cur(r_right_cur), .i_tgt(r_right_tgt), .i_cfg(r_cfg),
                        .o_next(n_right_cur));

    dmsr_bridge u_bridge_l (.i_speed(n_left_cur),  .i_cfg(r_cfg), .o_fwd(n_lf), .o_rev(n_lr));
    dmsr_bridge u_bridge_r (.i_speed(n_right_cur), .i_cfg(r_cfg), .o_fwd(n_rf), .o_rev(n_rr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACCEL_STEP:  r_cfg.accel_step  <= i_cfg_data[STEP_W-1:0];
                CFG_PWM_PERIOD:  r_cfg.pwm_period  <= i_cfg_data[PERIOD_W-1:0];
                CFG_DUTY_OFFSET: r_cfg.duty_offset <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in_cmd   <= t_cmd'(i_s_tuser[0]);
            r_in_motor <= t_motor'(i_s_tuser[1]);
            r_in_speed <= t_speed'(i_s_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_tgt  <= '0;
            r_right_tgt <= '0;
            r_left_cur  <= '0;
            r_right_cur <= '0;
        end else if (w_adv) begin
            if (r_in_cmd == CMD_SET) begin
                if (r_in_motor == MOTOR_LEFT) begin
                    r_left_tgt <= r_in_speed;
                end else begin
                    r_right_tgt <= r_in_speed;
                end
            end else begin
                r_left_cur  <= n_left_cur;
                r_right_cur <= n_right_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_lf <= n_lf;
            r_lr <= n_lr;
            r_rf <= n_rf;
            r_rr <= n_rr;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_rr, r_rf, r_lr, r_lf};

endmodule

>>> src/dmsr_ramp.sv
module dmsr_ramp
    import dmsr_pkg::*;
(
    input  t_speed i_cur,
    input  t_speed i_tgt,
    input  t_cfg   i_cfg,
    output t_speed o_next
);

    logic signed [SPEED_W+1:0] w_cur;
    logic signed [SPEED_W+1:0] w_tgt;
    logic signed [SPEED_W+1:0] w_step;
    logic signed [SPEED_W+1:0] w_up;
    logic signed [SPEED_W+1:0] w_dn;
    logic signed [SPEED_W+1:0] w_next;

    assign w_cur  = (SPEED_W+2)'(i_cur);
    assign w_tgt  = (SPEED_W+2)'(i_tgt);
    assign w_step = $signed({3'b000, i_cfg.accel_step});
    assign w_up   = w_cur + w_step;
    assign w_dn   = w_cur - w_step;

    always_comb begin
        if (w_cur < w_tgt) begin
            w_next = (w_up < w_tgt) ? w_up : w_tgt;
        end else if (w_cur > w_tgt) begin
            w_next = (w_dn > w_tgt) ? w_dn : w_tgt;
        end else begin
            w_next = w_cur;
        end
    end

    // result always lies between current and target, so it fits
    assign o_next = t_speed'(w_next[SPEED_W-1:0]);

endmodule

>>> src/dmsr_bridge.sv
module dmsr_bridge
    import dmsr_pkg::*;
(
    input  t_speed            i_speed,
    input  t_cfg              i_cfg,
    output logic [DUTY_W-1:0] o_fwd,
    output logic [DUTY_W-1:0] o_rev
);

    localparam int PROD_W = SPEED_W + 1 + PERIOD_W;

    logic signed [SPEED_W:0] w_ext;
    logic [SPEED_W:0]        w_mag;
    logic [PROD_W-1:0]       w_prod;
    logic [DUTY_W+3:0]       w_sum;
    logic [DUTY_W-1:0]       w_drive;
    logic                    w_pos;

    assign w_ext   = (SPEED_W+1)'(i_speed);
    assign w_mag   = w_ext[SPEED_W] ? $unsigned(-w_ext) : $unsigned(w_ext);
    assign w_prod  = PROD_W'(w_mag) * PROD_W'(i_cfg.pwm_period);
    assign w_sum   = (DUTY_W+4)'(w_prod[PROD_W-1:FRAC_W]) + (DUTY_W+4)'(i_cfg.duty_offset);
    assign w_drive = (w_sum[DUTY_W+3:DUTY_W] != '0) ? DUTY_MAX : w_sum[DUTY_W-1:0];
    assign w_pos   = (i_speed > 0);

    assign o_fwd = w_pos ? w_drive : i_cfg.duty_offset;
    assign o_rev = w_pos ? i_cfg.duty_offset : w_drive;

endmodule

>>> src/dmsr_checker.sv
module dmsr_checker
    import dmsr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [4*DUTY_W-1:0]  o_m_tdata
);

    logic [DUTY_W-1:0] w_lf, w_lr, w_rf, w_rr, w_lmin, w_rmin;

    assign w_lf   = o_m_tdata[DUTY_W-1:0];
    assign w_lr   = o_m_tdata[2*DUTY_W-1:DUTY_W];
    assign w_rf   = o_m_tdata[3*DUTY_W-1:2*DUTY_W];
    assign w_rr   = o_m_tdata[4*DUTY_W-1:3*DUTY_W];
    assign w_lmin = (w_lf < w_lr) ? w_lf : w_lr;
    assign w_rmin = (w_rf < w_rr) ? w_rf : w_rr;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // idle side of both motors is the shared offset
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_lmin == w_rmin)
        else $error("idle sides disagree");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready, 2))
        else $error("result without a matching item");

endmodule

bind dual_motor_speed_ramp_pwm_core dmsr_checker u_dmsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
